// ===== src/lru_pkg.sv =====
package lru_pkg;

  localparam int KEY_W        = 8;
  localparam int SLOT_W       = 3;
  localparam int TOTAL_W      = 32;
  localparam int DEFAULT_WAYS = 8;

  // One access request
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last_access;
  } req_t;

  // One result
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   evicted_key;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
  } rsp_t;

  // Broadcast to every cell: the request and the decisions taken over the whole row
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             act;        // nonzero key accepted this cycle
    logic             clr;        // run ends: wipe everything
    logic             miss;       // key held in no slot
    logic             any_empty;  // some slot is empty
    logic             any_victim; // some slot holds the stack bottom
    logic [KEY_W-1:0] victim;     // stack bottom
  } ctrl_t;

  // Running "already seen in an earlier cell" marks handed down the row
  typedef struct packed {
    logic slot_hit;
    logic empty;
    logic victim;
    logic stack_hit;
  } chain_t;

  // Per-cell status seen by the top level
  typedef struct packed {
    logic slot_match;
    logic first_hit;
    logic first_empty;
    logic first_victim;
  } flags_t;

endpackage

// ===== src/lru_cell.sv =====
module lru_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  lru_pkg::ctrl_t               ctrl,
  input  logic                         head,
  input  lru_pkg::chain_t              chain_in,
  input  logic [lru_pkg::KEY_W-1:0]    stack_up,
  output lru_pkg::chain_t              chain_out,
  output lru_pkg::flags_t              flags,
  output logic [lru_pkg::KEY_W-1:0]    slot_key,
  output logic [lru_pkg::KEY_W-1:0]    stack_key
);

  logic slot_match;
  logic is_empty;
  logic is_victim;
  logic stack_match;
  logic slot_write;
  logic stack_shift;

  // Local compares
  assign slot_match  = (slot_key == ctrl.key);
  assign is_empty    = (slot_key == '0);
  assign is_victim   = (slot_key == ctrl.victim);
  assign stack_match = (stack_key == ctrl.key);

  // Pass the sticky marks on to the next cell
  assign chain_out.slot_hit  = chain_in.slot_hit  | slot_match;
  assign chain_out.empty     = chain_in.empty     | is_empty;
  assign chain_out.victim    = chain_in.victim    | is_victim;
  assign chain_out.stack_hit = chain_in.stack_hit | stack_match;

  assign flags.slot_match   = slot_match;
  assign flags.first_hit    = slot_match & ~chain_in.slot_hit;
  assign flags.first_empty  = is_empty   & ~chain_in.empty;
  assign flags.first_victim = is_victim  & ~chain_in.victim;

  // Fill: first empty slot, else slot of the stack bottom, else the head slot
  always_comb begin
    slot_write = 1'b0;
    if (ctrl.act && ctrl.miss) begin
      if (ctrl.any_empty) begin
        slot_write = flags.first_empty;
      end else if (ctrl.any_victim) begin
        slot_write = flags.first_victim;
      end else begin
        slot_write = head;
      end
    end
  end

  // Stack entries at or above the hit position (every entry on a miss) move down one place
  assign stack_shift = ctrl.act & (ctrl.miss | ~chain_in.stack_hit);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      slot_key  <= '0;
      stack_key <= '0;
    end else begin
      if (slot_write) begin
        slot_key <= ctrl.key;
      end
      if (stack_shift) begin
        stack_key <= stack_up;
      end
    end
  end

endmodule

// ===== src/lru_cache_replacement.sv =====
// Channel  | Ports                 | Handshake
// ---------+-----------------------+-----------------------------------------
// request  | start, busy, request  | taken on a rising edge with start & !busy
// result   | done, result          | valid for one cycle while done is high
//
// One request per cycle while busy is low. The result appears in the cycle after the request.
// Lookup, fill and stack shift all happen in the row of cells in the cycle of the request.
// Reset (rst, synchronous) empties all slots, the stack and the totals;
// busy is high for the cycle that follows reset.
// The receiver cannot stall; a request marked last wipes the cache at the same edge.
module lru_cache_replacement #(
  parameter int WAYS = lru_pkg::DEFAULT_WAYS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lru_pkg::req_t request,
  output logic          done,
  output lru_pkg::rsp_t result
);

  localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  lru_pkg::ctrl_t  ctrl;
  lru_pkg::chain_t chain [WAYS+1];
  lru_pkg::flags_t flags [WAYS];
  logic [lru_pkg::KEY_W-1:0] slot_keys   [WAYS];
  logic [lru_pkg::KEY_W-1:0] stack_keys  [WAYS];
  logic [lru_pkg::KEY_W-1:0] stack_feed  [WAYS];
  logic [WAYS-1:0]           slot_match;

  logic                        accept;
  logic [lru_pkg::TOTAL_W-1:0] hits;
  logic [lru_pkg::TOTAL_W-1:0] misses;
  logic [lru_pkg::TOTAL_W-1:0] hits_next;
  logic [lru_pkg::TOTAL_W-1:0] misses_next;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W+lru_pkg::SLOT_W-1:0] idx_wide;
  logic [lru_pkg::KEY_W-1:0]   evicted;
  logic                        hit_now;

  assign accept = start & ~busy;

  // Broadcast control
  assign ctrl.key        = request.key;
  assign ctrl.act        = accept & (request.key != '0);
  assign ctrl.clr        = accept & request.last_access;
  assign ctrl.miss       = ~chain[WAYS].slot_hit;
  assign ctrl.any_empty  = chain[WAYS].empty;
  assign ctrl.any_victim = chain[WAYS].victim;
  assign ctrl.victim     = stack_keys[WAYS-1];

  assign chain[0] = '0;

  // Row of cells
  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign stack_feed[i] = request.key;
    end else begin : g_body
      assign stack_feed[i] = stack_keys[i-1];
    end
    assign slot_match[i] = flags[i].slot_match;

    lru_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .head      (1'(i == 0)),
      .chain_in  (chain[i]),
      .stack_up  (stack_feed[i]),
      .chain_out (chain[i+1]),
      .flags     (flags[i]),
      .slot_key  (slot_keys[i]),
      .stack_key (stack_keys[i])
    );
  end

  // Slot number of this access
  always_comb begin
    idx = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!ctrl.miss) begin
        if (flags[i].first_hit) idx = idx | IDX_W'(i);
      end else if (ctrl.any_empty) begin
        if (flags[i].first_empty) idx = idx | IDX_W'(i);
      end else if (ctrl.any_victim) begin
        if (flags[i].first_victim) idx = idx | IDX_W'(i);
      end
    end
  end
  assign idx_wide = {{lru_pkg::SLOT_W{1'b0}}, idx};

  // Evicted key only on a miss into a full row
  always_comb begin
    evicted = '0;
    if (ctrl.miss && !ctrl.any_empty) begin
      evicted = ctrl.any_victim ? ctrl.victim : slot_keys[0];
    end
  end

  assign hit_now = ctrl.act & ~ctrl.miss;

  // Saturating totals
  always_comb begin
    hits_next   = hits;
    misses_next = misses;
    if (ctrl.act) begin
      if (!ctrl.miss) begin
        if (hits != '1) hits_next = hits + 1'b1;
      end else begin
        if (misses != '1) misses_next = misses + 1'b1;
      end
    end
  end

  // Counters, result register and handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      hits   <= '0;
      misses <= '0;
      done   <= 1'b0;
      busy   <= 1'b1;
    end else begin
      busy <= 1'b0;
      done <= accept;
      if (ctrl.clr) begin
        hits   <= '0;
        misses <= '0;
      end else begin
        hits   <= hits_next;
        misses <= misses_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.hit         <= hit_now;
      result.slot        <= ctrl.act ? idx_wide[lru_pkg::SLOT_W-1:0] : '0;
      result.evicted_key <= ctrl.act ? evicted : '0;
      result.hit_total   <= hits_next;
      result.miss_total  <= misses_next;
    end
  end

`ifndef SYNTHESIS
  // A result only follows an accepted request
  a_done_follows_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without request");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && result.hit) |-> (result.evicted_key == '0))
    else $error("eviction reported on a hit");

  // Nonzero keys sit in at most one slot
  a_unique_slot: assert property (@(posedge clk) disable iff (rst)
    (request.key != '0) |-> $onehot0(slot_match))
    else $error("key held in more than one slot");

  // End of run wipes the totals
  a_clear_totals: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.last_access) |=> (hits == '0 && misses == '0))
    else $error("totals not cleared after last access");
`endif

endmodule
